FILE: design/rbcb_pkg.sv
package rbcb_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int SQ_W    = 32;
  localparam int SUM_W   = 34;
  localparam int ROOT_W  = 17;
  localparam int ISQ_W   = 35;
  localparam int RAD_W   = 16;
  localparam int COLOR_W = 32;
  localparam int CH_W    = 8;
  localparam int NCH     = 3;
  localparam int NUM_W   = 24;
  localparam int PROD_W  = 26;
  localparam int QBITS   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COLOR_W-1:0] BRUSH_COLOR_RST = 32'hFF80_8080;
  localparam logic [CH_W-1:0]    ALPHA_OPAQUE    = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_CENTER_Z      = 3'd2,
    CFG_BRUSH_RADIUS  = 3'd3,
    CFG_BRUSH_COLOR   = 3'd4,
    CFG_CYLINDER_MODE = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_KEEP = 2'd0,
    KIND_FILL = 2'd1,
    KIND_RING = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RAD_W-1:0]          radius;
    logic [COLOR_W-1:0]        color;
    logic                      cylinder;
    logic [RAD_W-1:0]          fade;
    logic [RAD_W-1:0]          inner;
  } cfg_t;

  typedef struct packed {
    logic                          valid;
    kind_t                         kind;
    logic [COLOR_W-1:0]            old_color;
    logic [NCH-1:0][CH_W-1:0]      quo;
  } blend_out_t;

endpackage

FILE: design/rbcb_cfg.sv
module rbcb_cfg #(
  parameter int FADE_PORTION = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [rbcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbcb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rbcb_pkg::cfg_t                      cfg
);

  localparam int RW          = rbcb_pkg::RAD_W;
  localparam int FADE_SHIFT  = RW + $clog2(FADE_PORTION);
  localparam int MW          = RW + 1;
  localparam int PW          = RW + MW;
  localparam logic [MW-1:0] FADE_MULT =
    MW'(((64'd1 << FADE_SHIFT) + 64'(FADE_PORTION) - 64'd1) / 64'(FADE_PORTION));

  logic signed [rbcb_pkg::COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [RW-1:0]                       radius_r;
  logic [rbcb_pkg::COLOR_W-1:0]        color_r;
  logic                                cylinder_r;
  logic [PW-1:0]                       prod_r;
  logic [RW-1:0]                       fade_r, inner_r;
  logic [PW-1:0]                       prod_nxt;
  logic [RW-1:0]                       fade_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= '0;
      color_r    <= rbcb_pkg::BRUSH_COLOR_RST;
      cylinder_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rbcb_pkg::CFG_CENTER_X:      center_x_r <= cfg_data[rbcb_pkg::COORD_W-1:0];
        rbcb_pkg::CFG_CENTER_Y:      center_y_r <= cfg_data[rbcb_pkg::COORD_W-1:0];
        rbcb_pkg::CFG_CENTER_Z:      center_z_r <= cfg_data[rbcb_pkg::COORD_W-1:0];
        rbcb_pkg::CFG_BRUSH_RADIUS:  radius_r   <= cfg_data[RW-1:0];
        rbcb_pkg::CFG_BRUSH_COLOR:   color_r    <= cfg_data[rbcb_pkg::COLOR_W-1:0];
        rbcb_pkg::CFG_CYLINDER_MODE: cylinder_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // fade width = radius / FADE_PORTION via reciprocal multiply
  assign prod_nxt = PW'(radius_r) * PW'(FADE_MULT);
  assign fade_nxt = RW'(prod_r >> FADE_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r  <= '0;
      fade_r  <= '0;
      inner_r <= '0;
    end else begin
      prod_r  <= prod_nxt;
      fade_r  <= fade_nxt;
      inner_r <= radius_r - fade_r;
    end
  end

  always_comb begin
    cfg.center_x = center_x_r;
    cfg.center_y = center_y_r;
    cfg.center_z = center_z_r;
    cfg.radius   = radius_r;
    cfg.color    = color_r;
    cfg.cylinder = cylinder_r;
    cfg.fade     = fade_r;
    cfg.inner    = inner_r;
  end

endmodule

FILE: design/rbcb_dist.sv
module rbcb_dist (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  rbcb_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  input  logic signed [rbcb_pkg::COORD_W-1:0] vertex_x,
  input  logic signed [rbcb_pkg::COORD_W-1:0] vertex_y,
  input  logic signed [rbcb_pkg::COORD_W-1:0] vertex_z,
  input  logic [rbcb_pkg::COLOR_W-1:0]        old_color,
  output logic                                sum_valid,
  output logic [rbcb_pkg::SUM_W-1:0]          sum,
  output logic [rbcb_pkg::COLOR_W-1:0]        sum_old_color
);

  localparam int DW = rbcb_pkg::DIFF_W;
  localparam int SW = rbcb_pkg::SQ_W;
  localparam int UW = rbcb_pkg::SUM_W;
  localparam int PW = 2 * DW;

  logic                           v0_r, v1_r, v2_r;
  logic signed [DW-1:0]           dx_r, dy_r, dz_r;
  logic signed [DW-1:0]           dx_nxt, dy_nxt, dz_nxt;
  logic [SW-1:0]                  sqx_r, sqy_r, sqz_r;
  logic signed [PW-1:0]           px, py, pz;
  logic [UW-1:0]                  sum_r, sum_nxt;
  logic [rbcb_pkg::COLOR_W-1:0]   old0_r, old1_r, old2_r;

  assign dx_nxt = {cfg.center_x[15], cfg.center_x} - {vertex_x[15], vertex_x};
  assign dy_nxt = {cfg.center_y[15], cfg.center_y} - {vertex_y[15], vertex_y};
  assign dz_nxt = {cfg.center_z[15], cfg.center_z} - {vertex_z[15], vertex_z};

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  assign sum_nxt = UW'(sqx_r) + UW'(sqy_r) + (cfg.cylinder ? UW'(0) : UW'(sqz_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      dz_r   <= dz_nxt;
      old0_r <= old_color;
      sqx_r  <= px[SW-1:0];
      sqy_r  <= py[SW-1:0];
      sqz_r  <= pz[SW-1:0];
      old1_r <= old0_r;
      sum_r  <= sum_nxt;
      old2_r <= old1_r;
    end
  end

  assign sum_valid     = v2_r;
  assign sum           = sum_r;
  assign sum_old_color = old2_r;

endmodule

FILE: design/rbcb_isqrt.sv
module rbcb_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           sum_valid,
  input  logic [rbcb_pkg::SUM_W-1:0]     sum,
  input  logic [rbcb_pkg::COLOR_W-1:0]   sum_old_color,
  output logic                           root_valid,
  output logic [rbcb_pkg::ROOT_W-1:0]    root,
  output logic [rbcb_pkg::COLOR_W-1:0]   root_old_color
);

  localparam int NS = rbcb_pkg::ROOT_W;
  localparam int W  = rbcb_pkg::ISQ_W;
  localparam int CW = rbcb_pkg::COLOR_W;

  logic          vld_r [NS];
  logic [W-1:0]  rem_r [NS];
  logic [W-1:0]  res_r [NS];
  logic [CW-1:0] old_r [NS];

  // one result bit per stage, highest first
  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (2 * (NS - 1 - g));
    logic          v_i;
    logic [W-1:0]  rem_i, res_i, trial;
    logic [W-1:0]  rem_nxt, res_nxt;
    logic [CW-1:0] old_i;

    if (g == 0) begin : g_first
      assign v_i   = sum_valid;
      assign rem_i = W'(sum);
      assign res_i = '0;
      assign old_i = sum_old_color;
    end else begin : g_next
      assign v_i   = vld_r[g-1];
      assign rem_i = rem_r[g-1];
      assign res_i = res_r[g-1];
      assign old_i = old_r[g-1];
    end

    always_comb begin
      trial = res_i + BIT;
      if (rem_i >= trial) begin
        rem_nxt = rem_i - trial;
        res_nxt = (res_i >> 1) + BIT;
      end else begin
        rem_nxt = rem_i;
        res_nxt = res_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        res_r[g] <= res_nxt;
        old_r[g] <= old_i;
      end
    end
  end

  assign root_valid     = vld_r[NS-1];
  assign root           = res_r[NS-1][NS-1:0];
  assign root_old_color = old_r[NS-1];

endmodule

FILE: design/rbcb_blend.sv
module rbcb_blend (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  rbcb_pkg::cfg_t                 cfg,
  input  logic                           root_valid,
  input  logic [rbcb_pkg::ROOT_W-1:0]    root,
  input  logic [rbcb_pkg::COLOR_W-1:0]   root_old_color,
  output rbcb_pkg::blend_out_t           blend_out
);

  localparam int RW  = rbcb_pkg::RAD_W;
  localparam int CH  = rbcb_pkg::CH_W;
  localparam int NC  = rbcb_pkg::NCH;
  localparam int NW  = rbcb_pkg::NUM_W;
  localparam int PW  = rbcb_pkg::PROD_W;
  localparam int QB  = rbcb_pkg::QBITS;
  localparam int CW  = rbcb_pkg::COLOR_W;

  // classify
  logic                 c0_v_r;
  rbcb_pkg::kind_t      c0_kind_r, kind_nxt;
  logic [RW-1:0]        c0_n_r, n_nxt;
  logic [CW-1:0]        c0_old_r;

  always_comb begin
    n_nxt = root[RW-1:0] - cfg.inner;
    if (root >= {1'b0, cfg.radius}) begin
      kind_nxt = rbcb_pkg::KIND_KEEP;
    end else if (root <= {1'b0, cfg.inner}) begin
      kind_nxt = rbcb_pkg::KIND_FILL;
    end else begin
      kind_nxt = rbcb_pkg::KIND_RING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_v_r <= 1'b0;
    end else if (en) begin
      c0_v_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_kind_r <= kind_nxt;
      c0_n_r    <= n_nxt;
      c0_old_r  <= root_old_color;
    end
  end

  // products b*F and (o-b)*n per channel
  logic                        c1_v_r;
  rbcb_pkg::kind_t             c1_kind_r;
  logic [CW-1:0]               c1_old_r;
  logic [NC-1:0][NW-1:0]       c1_bf_r, bf_nxt;
  logic signed [PW-1:0]        c1_on_r [NC];
  logic signed [PW-1:0]        on_nxt [NC];
  logic signed [CH:0]          diff [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      diff[c]   = $signed({1'b0, c0_old_r[c*CH +: CH]}) - $signed({1'b0, cfg.color[c*CH +: CH]});
      bf_nxt[c] = NW'(cfg.color[c*CH +: CH]) * NW'(cfg.fade);
      on_nxt[c] = PW'(diff[c]) * $signed(PW'({1'b0, c0_n_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= c0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_kind_r <= c0_kind_r;
      c1_old_r  <= c0_old_r;
      c1_bf_r   <= bf_nxt;
      for (int c = 0; c < NC; c++) begin
        c1_on_r[c] <= on_nxt[c];
      end
    end
  end

  // numerator
  logic                   c2_v_r;
  rbcb_pkg::kind_t        c2_kind_r;
  logic [CW-1:0]          c2_old_r;
  logic [NC-1:0][NW-1:0]  c2_num_r, num_nxt;
  logic signed [PW-1:0]   num_wide [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      num_wide[c] = $signed(PW'(c1_bf_r[c])) + c1_on_r[c];
      num_nxt[c]  = num_wide[c][NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_v_r <= 1'b0;
    end else if (en) begin
      c2_v_r <= c1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_kind_r <= c1_kind_r;
      c2_old_r  <= c1_old_r;
      c2_num_r  <= num_nxt;
    end
  end

  // restoring division by the fade width, one quotient bit per stage
  logic                   dv_r   [QB];
  rbcb_pkg::kind_t        dk_r   [QB];
  logic [CW-1:0]          dold_r [QB];
  logic [NC-1:0][NW-1:0]  drem_r [QB];
  logic [NC-1:0][CH-1:0]  dquo_r [QB];

  for (genvar g = 0; g < QB; g++) begin : g_div
    localparam int K = QB - 1 - g;
    logic                  v_i;
    rbcb_pkg::kind_t       k_i;
    logic [CW-1:0]         old_i;
    logic [NC-1:0][NW-1:0] rem_i, rem_nxt;
    logic [NC-1:0][CH-1:0] quo_i, quo_nxt;
    logic [NW-1:0]         dvs;

    if (g == 0) begin : g_first
      assign v_i   = c2_v_r;
      assign k_i   = c2_kind_r;
      assign old_i = c2_old_r;
      assign rem_i = c2_num_r;
      assign quo_i = '0;
    end else begin : g_next
      assign v_i   = dv_r[g-1];
      assign k_i   = dk_r[g-1];
      assign old_i = dold_r[g-1];
      assign rem_i = drem_r[g-1];
      assign quo_i = dquo_r[g-1];
    end

    always_comb begin
      dvs     = NW'(cfg.fade) << K;
      rem_nxt = rem_i;
      quo_nxt = quo_i;
      for (int c = 0; c < NC; c++) begin
        if (rem_i[c] >= dvs) begin
          rem_nxt[c]    = rem_i[c] - dvs;
          quo_nxt[c][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[g] <= 1'b0;
      end else if (en) begin
        dv_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dk_r[g]   <= k_i;
        dold_r[g] <= old_i;
        drem_r[g] <= rem_nxt;
        dquo_r[g] <= quo_nxt;
      end
    end
  end

  always_comb begin
    blend_out.valid     = dv_r[QB-1];
    blend_out.kind      = dk_r[QB-1];
    blend_out.old_color = dold_r[QB-1];
    blend_out.quo       = dquo_r[QB-1];
  end

endmodule

FILE: design/radial_brush_color_blend.sv
// Radial brush color blend. Each item is one vertex (x, y, z, ARGB color); each
// item gives exactly one result: the new color and a touched flag that is set
// when the floor distance to the brush center is below the brush radius.
// Vertices inside the inner radius take the brush color, vertices in the fade
// ring get a per-channel linear blend toward their old color with alpha 255,
// all others keep their color. The datapath is a 32-stage pipeline (three
// stages of difference/square/sum, 17 square-root stages, three blend set-up
// stages, 8 divider stages and the output register), and a new item is
// taken every cycle while the output side keeps up. The whole pipeline
// holds while a result waits at the output. Fade width and inner radius
// are derived from the radius register through the prod, fade and inner
// registers, in that order, after a write.
module radial_brush_color_blend #(
  parameter int FADE_PORTION = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rbcb_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [rbcb_pkg::COORD_W-1:0] in_vertex_y,
  input  logic signed [rbcb_pkg::COORD_W-1:0] in_vertex_z,
  input  logic [rbcb_pkg::COLOR_W-1:0]        in_old_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rbcb_pkg::COLOR_W-1:0]        out_new_color,
  output logic                                out_touched,
  input  logic                                cfg_wr_en,
  input  logic [rbcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbcb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rbcb_pkg::cfg_t                    cfg;
  rbcb_pkg::blend_out_t              blend_out;
  logic                              en;
  logic                              sum_valid, root_valid;
  logic [rbcb_pkg::SUM_W-1:0]        sum;
  logic [rbcb_pkg::ROOT_W-1:0]       root;
  logic [rbcb_pkg::COLOR_W-1:0]      sum_old_color, root_old_color;
  logic                              out_valid_r;
  logic [rbcb_pkg::COLOR_W-1:0]      new_color_r, new_color_nxt;
  logic                              touched_r, touched_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  rbcb_cfg #(.FADE_PORTION(FADE_PORTION)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbcb_dist u_dist (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .vertex_x      (in_vertex_x),
    .vertex_y      (in_vertex_y),
    .vertex_z      (in_vertex_z),
    .old_color     (in_old_color),
    .sum_valid     (sum_valid),
    .sum           (sum),
    .sum_old_color (sum_old_color)
  );

  rbcb_isqrt u_isqrt (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .sum_valid      (sum_valid),
    .sum            (sum),
    .sum_old_color  (sum_old_color),
    .root_valid     (root_valid),
    .root           (root),
    .root_old_color (root_old_color)
  );

  rbcb_blend u_blend (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .cfg            (cfg),
    .root_valid     (root_valid),
    .root           (root),
    .root_old_color (root_old_color),
    .blend_out      (blend_out)
  );

  always_comb begin
    unique case (blend_out.kind)
      rbcb_pkg::KIND_FILL: begin
        new_color_nxt = cfg.color;
        touched_nxt   = 1'b1;
      end
      rbcb_pkg::KIND_RING: begin
        new_color_nxt = {rbcb_pkg::ALPHA_OPAQUE, blend_out.quo};
        touched_nxt   = 1'b1;
      end
      default: begin
        new_color_nxt = blend_out.old_color;
        touched_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= blend_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_color_r <= new_color_nxt;
      touched_r   <= touched_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_color = new_color_r;
  assign out_touched   = touched_r;

endmodule

FILE: design/rbcb_checker.sv
module rbcb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rbcb_pkg::COLOR_W-1:0]    out_new_color,
  input logic                            out_touched,
  input logic                            cfg_wr_en,
  input logic [rbcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [rbcb_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic radius_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_zero_r <= 1'b1;
    end else if (cfg_wr_en && cfg_index == rbcb_pkg::CFG_BRUSH_RADIUS) begin
      radius_zero_r <= (cfg_data[rbcb_pkg::RAD_W-1:0] == '0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_new_color) && $stable(out_touched))
    else $error("result changed while stalled");

  a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_zero_radius_untouched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && radius_zero_r |-> !out_touched)
    else $error("touched with zero radius");

endmodule

bind radial_brush_color_blend rbcb_checker u_rbcb_checker (.*);
